[hdl/cordic_ang_pkg.sv]
// ----------------------------------------------------------------------------
// cordic_ang_pkg
// widths, arctangent table and constants for the cordic angle unit
// ----------------------------------------------------------------------------
`default_nettype none

package cordic_ang_pkg;

    // input component width and number of micro-rotations
    localparam int DATA_WIDTH = 16;
    localparam int ITERATIONS = 8;

    // internal x/y width: abs of the most negative input plus cordic gain growth
    localparam int XY_W    = DATA_WIDTH + 4;
    localparam int ANGLE_W = 17;

    // pipeline: abs stage, one stage per rotation, mirror/output stage
    localparam int STAGES = ITERATIONS + 2;

    // stream widths padded to whole bytes
    localparam int S_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ANGLE_W + 7) / 8) * 8;

    typedef logic signed [XY_W-1:0]    t_xy;
    typedef logic signed [ANGLE_W-1:0] t_angle;

    // 180 degrees in 1/256 degree units
    localparam t_angle HALF_TURN = 17'sd46080;

    // atan(2^-i) in 1/256 degree units
    localparam t_angle ATAN_TABLE [15] = '{
        17'sd11520, 17'sd6801, 17'sd3593, 17'sd1824, 17'sd916,
        17'sd458,   17'sd229,  17'sd115,  17'sd57,   17'sd29,
        17'sd14,    17'sd7,    17'sd4,    17'sd2,    17'sd1
    };

endpackage

`default_nettype wire

[hdl/cordic_atan2_angle_unit.sv]
// ----------------------------------------------------------------------------
// cordic_atan2_angle_unit
// pipelined cordic vectoring: angle of a signed (x, y) vector in 1/256 degree
// ----------------------------------------------------------------------------
// Takes one (x, y) word per cycle on the slave stream and returns the angle of
// the vector on the master stream, in 1/256 degree units (46080 = 180 degrees,
// range -46080..46079). The word passes through registered stages in order:
// one stage folds a negative x into the right half plane, one stage per
// unrolled micro-rotation, and one stage mirrors the angle back and holds the
// output word. Throughput is one word per cycle, set by the unrolled rotation
// stages; each stage holds its word while the stage after it is full and
// held, so a stalled output fills empty stages first and s_axis_tready only
// drops once the whole pipeline is occupied. A zero y rotates in the negative
// direction, so the zero vector returns -25456.
// ----------------------------------------------------------------------------
`default_nettype none

module cordic_atan2_angle_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // slave side
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [cordic_ang_pkg::S_TDATA_W-1:0] s_axis_tdata,  // x_coord[15:0], y_coord[31:16]
    // master side
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [cordic_ang_pkg::M_TDATA_W-1:0]      m_axis_tdata   // angle[16:0], zero pad[23:17]
);
    import cordic_ang_pkg::*;

    localparam int LAST = STAGES - 1;

    // per-stage valid bits and advance enables
    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] adv;

    // rotation stage registers: index 0 is the abs stage, k is after rotation k-1
    t_xy    r_x   [0:ITERATIONS];
    t_xy    r_y   [0:ITERATIONS];
    t_angle r_acc [0:ITERATIONS];
    logic   r_mir [0:ITERATIONS];
    t_angle r_angle;

    t_xy    n_x   [0:ITERATIONS];
    t_xy    n_y   [0:ITERATIONS];
    t_angle n_acc [0:ITERATIONS];
    logic   n_mir [0:ITERATIONS];
    t_angle n_angle;

    logic signed [DATA_WIDTH-1:0] in_x;
    logic signed [DATA_WIDTH-1:0] in_y;
    t_xy                          in_x_ext;

    // a stage takes a new word when it is empty or its word moves on
    always_comb begin
        adv[LAST] = !r_v[LAST] || m_axis_tready;
        for (int k = LAST - 1; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign s_axis_tready = adv[0];

    // unpack and fold a negative x into the right half plane
    assign in_x     = s_axis_tdata[DATA_WIDTH-1:0];
    assign in_y     = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign in_x_ext = {{(XY_W-DATA_WIDTH){in_x[DATA_WIDTH-1]}}, in_x};

    always_comb begin
        n_mir[0] = in_x[DATA_WIDTH-1];
        n_x[0]   = in_x[DATA_WIDTH-1] ? -in_x_ext : in_x_ext;
        n_y[0]   = {{(XY_W-DATA_WIDTH){in_y[DATA_WIDTH-1]}}, in_y};
        n_acc[0] = '0;
    end

    // one micro-rotation per stage, shift by the stage's own constant
    for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
        t_xy xs;
        t_xy ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;

        always_comb begin
            n_mir[i+1] = r_mir[i];
            if (r_y[i] > 0) begin
                n_x[i+1]   = r_x[i] + ys;
                n_y[i+1]   = r_y[i] - xs;
                n_acc[i+1] = r_acc[i] + ATAN_TABLE[i];
            end else begin
                // zero y takes the negative direction
                n_x[i+1]   = r_x[i] - ys;
                n_y[i+1]   = r_y[i] + xs;
                n_acc[i+1] = r_acc[i] - ATAN_TABLE[i];
            end
        end
    end

    // mirror back into the left half plane when x was negative
    always_comb begin
        if (!r_mir[ITERATIONS]) begin
            n_angle = r_acc[ITERATIONS];
        end else if (r_acc[ITERATIONS] > 0) begin
            n_angle = HALF_TURN - r_acc[ITERATIONS];
        end else begin
            n_angle = -HALF_TURN - r_acc[ITERATIONS];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // payload, loaded only when a word moves into the stage
    always_ff @(posedge i_clk) begin
        if (adv[0] && s_axis_tvalid) begin
            r_x[0]   <= n_x[0];
            r_y[0]   <= n_y[0];
            r_acc[0] <= n_acc[0];
            r_mir[0] <= n_mir[0];
        end
        for (int k = 1; k <= ITERATIONS; k++) begin
            if (adv[k] && r_v[k-1]) begin
                r_x[k]   <= n_x[k];
                r_y[k]   <= n_y[k];
                r_acc[k] <= n_acc[k];
                r_mir[k] <= n_mir[k];
            end
        end
        if (adv[LAST] && r_v[LAST-1]) begin
            r_angle <= n_angle;
        end
    end

    assign m_axis_tvalid = r_v[LAST];
    assign m_axis_tdata  = {{(M_TDATA_W-ANGLE_W){1'b0}}, r_angle};

endmodule

`default_nettype wire

[hdl/cordic_ang_checker.sv]
// ----------------------------------------------------------------------------
// cordic_ang_checker
// port-level checks for the cordic angle unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module cordic_ang_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    input  wire logic                                 s_axis_tready,
    input  wire logic [cordic_ang_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                                 m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    input  wire logic [cordic_ang_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import cordic_ang_pkg::*;

    // pipeline empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid right after reset");

    // angle stays within a half turn either way
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[ANGLE_W-1:0]) <= HALF_TURN) &&
            ($signed(m_axis_tdata[ANGLE_W-1:0]) >= -HALF_TURN))
        else $error("angle outside +-180 degrees");

    // pad bits above the angle are zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:ANGLE_W] == '0))
        else $error("nonzero pad bits in output word");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word dropped or changed");

endmodule

bind cordic_atan2_angle_unit cordic_ang_checker u_cordic_ang_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
